// ===== rtl/utf8cc_pkg.sv =====
`timescale 1ns / 1ps

package utf8cc_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int TALLY_N     = 6;
   localparam int EVENT_N     = 3;
   localparam int CP_W        = 21;
   localparam int BYTE_W      = 8;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_DATA_W  = TALLY_N * COUNT_WIDTH;
   localparam int RSP_TDATA_W = ((RSP_DATA_W + 7) / 8) * 8;

   // tally slots, lowest slot lands in the lowest bits of the result
   localparam int TALLY_TOTAL  = 0;
   localparam int TALLY_LETTER = 1;
   localparam int TALLY_DIGIT  = 2;
   localparam int TALLY_BLANK  = 3;
   localparam int TALLY_SYMBOL = 4;
   localparam int TALLY_EMOJI  = 5;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [1:0]             inc_type;
   typedef logic [BYTE_W-1:0]      byte_type;
   typedef logic [CP_W-1:0]        point_type;

   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_LETTER,
      CLS_DIGIT,
      CLS_BLANK,
      CLS_SYMBOL,
      CLS_EMOJI
   } cls_type;

   // one counted code point
   typedef struct packed {
      logic    hit;
      cls_type cls;
   } event_type;

   // number of continuation bytes a lead byte asks for, zero if not a lead
   function automatic logic [1:0] tail_len(input byte_type c);
      if (c[7:5] == 3'h6) begin
         return 2'd1;
      end else if (c[7:4] == 4'hE) begin
         return 2'd2;
      end else if (c[7:3] == 5'h1E) begin
         return 2'd3;
      end
      return 2'd0;
   endfunction

   function automatic cls_type ascii_class(input byte_type c);
      cls_type r;
      r = CLS_NONE;
      if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
         r = CLS_LETTER;
      end else if (c >= "0" && c <= "9") begin
         r = CLS_DIGIT;
      end else if (c == " " || c == 8'h09) begin
         r = CLS_BLANK;
      end else begin
         case (c)
            "{", "}", "[", "]", "(", ")", ";", "=", "<", ">", "_",
            "#", "/", "*", "+", "-", "&", "|", "^", "~",
            8'h60: begin // backquote
               r = CLS_SYMBOL;
            end
            default: begin
               r = CLS_NONE;
            end
         endcase
      end
      return r;
   endfunction

   function automatic cls_type point_class(input point_type cp);
      cls_type r;
      r = CLS_NONE;
      if ((cp >= 21'h00041 && cp <= 21'h0024F) || (cp >= 21'h00400 && cp <= 21'h004FF) ||
          (cp >= 21'h00600 && cp <= 21'h006FF) || (cp >= 21'h00900 && cp <= 21'h0097F) ||
          (cp >= 21'h04E00 && cp <= 21'h09FFF) || (cp >= 21'h03040 && cp <= 21'h030FF) ||
          (cp >= 21'h0AC00 && cp <= 21'h0D7AF)) begin
         r = CLS_LETTER;
      end else if ((cp >= 21'h1F600 && cp <= 21'h1F64F) ||
                   (cp >= 21'h1F300 && cp <= 21'h1F5FF) ||
                   (cp >= 21'h1F900 && cp <= 21'h1F9FF) ||
                   (cp >= 21'h1FA70 && cp <= 21'h1FAFF) ||
                   (cp >= 21'h02600 && cp <= 21'h026FF)) begin
         r = CLS_EMOJI;
      end
      return r;
   endfunction

endpackage

// ===== rtl/utf8_char_class_counter.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Content                                     Transfer
// req      in   tdata: text_byte; tlast: end_of_string       one per string byte
// rsp      out  tdata: six 16-bit counts, total at bit 0     one per string
//
// One byte enters per cycle unless a final byte waits on a held result. A byte
// is held in the input register; decoder state and counters update as it leaves,
// so throughput is one byte per clock, and the final byte's counts go to the result register.
// Reset clears the decoder, the counters and both valid flags.
// A stalled result only holds back a final byte; ordinary bytes keep flowing
// while the result register waits for rsp_tready.
module utf8_char_class_counter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [utf8cc_pkg::REQ_TDATA_W-1:0]     req_tdata,  // [7:0] text_byte
   input  logic                                   req_tlast,  // end_of_string
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // total_points, letter_count, digit_count, blank_count, symbol_count,
   // emoji_count, 16 bits each from bit 0 up
   output logic [utf8cc_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import utf8cc_pkg::*;

   // input register
   logic      in_valid_ff, in_valid_in;
   byte_type  in_byte_ff;
   logic      in_last_ff;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic      fire;
   event_type [EVENT_N-1:0] events;
   count_type [TALLY_N-1:0] sums;

   // a final byte may leave only when the result slot is free or freeing
   assign fire       = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !fire);
   assign rsp_valid_in = (fire && in_last_ff) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata[BYTE_W-1:0];
         in_last_ff <= req_tlast;
      end
      if (fire && in_last_ff) begin
         rsp_data_ff <= sums;
      end
   end

   utf8cc_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .text_byte (in_byte_ff),
      .last      (in_last_ff),
      .events    (events)
   );

   utf8cc_tally u_tally (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .last   (in_last_ff),
      .events (events),
      .sums   (sums)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

endmodule

// ===== rtl/utf8cc_decode.sv =====
`timescale 1ns / 1ps

// UTF-8 sequence tracker: turns one byte into up to three counted events
module utf8cc_decode (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              fire,
   input  utf8cc_pkg::byte_type                              text_byte,
   input  logic                                              last,
   output utf8cc_pkg::event_type [utf8cc_pkg::EVENT_N-1:0]   events
);
   import utf8cc_pkg::*;

   logic [1:0] owed_ff, owed_in;
   byte_type   lead_ff, lead_in;
   logic [1:0] fill_ff, fill_in;
   byte_type   tail_ff [3];
   logic       tail_we;

   byte_type   t0, t1;
   point_type  cp_main, cp_pair, cp_sel;
   cls_type    pcls;
   logic [1:0] b_len;
   logic       pair;

   function automatic event_type single(input byte_type x);
      event_type e;
      e.hit = 1'b1;
      e.cls = x[7] ? CLS_NONE : ascii_class(x);
      return e;
   endfunction

   // current byte merged into the held continuation bytes
   assign t0 = (fill_ff == 2'd0) ? text_byte : tail_ff[0];
   assign t1 = (fill_ff == 2'd1) ? text_byte : tail_ff[1];

   always_comb begin
      unique case (fill_ff)
         2'd0: cp_main = point_type'({lead_ff[4:0], t0[5:0]});
         2'd1: cp_main = point_type'({lead_ff[3:0], t0[5:0], t1[5:0]});
         2'd2: cp_main = point_type'({lead_ff[2:0], t0[5:0], t1[5:0], text_byte[5:0]});
         default: cp_main = '0;
      endcase
   end

   // truncated string, the held byte and the final byte forming a two-byte sequence
   assign pair    = (fill_ff == 2'd1) && tail_ff[0][7] && (tail_len(tail_ff[0]) == 2'd1);
   assign cp_pair = point_type'({tail_ff[0][4:0], text_byte[5:0]});
   assign cp_sel  = (owed_ff == 2'd1) ? cp_main : cp_pair;
   assign pcls    = point_class(cp_sel);
   assign b_len   = tail_len(text_byte);

   always_comb begin
      events  = '0;
      owed_in = owed_ff;
      lead_in = lead_ff;
      fill_in = fill_ff;
      tail_we = 1'b0;
      if (owed_ff == 2'd0) begin
         if (!text_byte[7]) begin
            events[0] = single(text_byte);
         end else if (b_len == 2'd0 || last) begin
            events[0] = '{hit: 1'b1, cls: CLS_NONE};
         end else begin
            owed_in = b_len;
            lead_in = text_byte;
            fill_in = 2'd0;
         end
      end else begin
         tail_we = 1'b1;
         fill_in = fill_ff + 2'd1;
         owed_in = owed_ff - 2'd1;
         if (owed_ff == 2'd1) begin
            events[0] = '{hit: 1'b1, cls: pcls};
            fill_in   = 2'd0;
         end else if (last) begin
            // lead counts bare, held bytes decoded again on their own
            events[0] = '{hit: 1'b1, cls: CLS_NONE};
            if (pair) begin
               events[1] = '{hit: 1'b1, cls: pcls};
            end else begin
               events[1] = single(t0);
               if (fill_ff == 2'd1) begin
                  events[2] = single(text_byte);
               end
            end
         end
      end
      if (last) begin
         owed_in = 2'd0;
         lead_in = '0;
         fill_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff <= 2'd0;
         lead_ff <= '0;
         fill_ff <= 2'd0;
      end else if (fire) begin
         owed_ff <= owed_in;
         lead_ff <= lead_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && tail_we && fill_ff != 2'd3) begin
         tail_ff[fill_ff] <= text_byte;
      end
   end

endmodule

// ===== rtl/utf8cc_tally.sv =====
`timescale 1ns / 1ps

// six saturating class counters, cleared after the final byte
module utf8cc_tally (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  fire,
   input  logic                                                  last,
   input  utf8cc_pkg::event_type [utf8cc_pkg::EVENT_N-1:0]       events,
   output utf8cc_pkg::count_type [utf8cc_pkg::TALLY_N-1:0]       sums
);
   import utf8cc_pkg::*;

   count_type tally_ff [TALLY_N];
   count_type tally_in [TALLY_N];
   inc_type   inc [TALLY_N];

   function automatic inc_type hits_of(input event_type [EVENT_N-1:0] ev,
                                       input logic any, input cls_type c);
      inc_type n;
      n = '0;
      for (int i = 0; i < EVENT_N; i++) begin
         if (ev[i].hit && (any || ev[i].cls == c)) begin
            n = n + inc_type'(1);
         end
      end
      return n;
   endfunction

   always_comb begin
      inc[TALLY_TOTAL]  = hits_of(events, 1'b1, CLS_NONE);
      inc[TALLY_LETTER] = hits_of(events, 1'b0, CLS_LETTER);
      inc[TALLY_DIGIT]  = hits_of(events, 1'b0, CLS_DIGIT);
      inc[TALLY_BLANK]  = hits_of(events, 1'b0, CLS_BLANK);
      inc[TALLY_SYMBOL] = hits_of(events, 1'b0, CLS_SYMBOL);
      inc[TALLY_EMOJI]  = hits_of(events, 1'b0, CLS_EMOJI);
   end

   always_comb begin
      logic [COUNT_WIDTH:0] s;
      for (int j = 0; j < TALLY_N; j++) begin
         s = {1'b0, tally_ff[j]} + (COUNT_WIDTH+1)'(inc[j]);
         sums[j]     = s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
         tally_in[j] = last ? '0 : sums[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < TALLY_N; j++) begin
            tally_ff[j] <= '0;
         end
      end else if (fire) begin
         for (int j = 0; j < TALLY_N; j++) begin
            tally_ff[j] <= tally_in[j];
         end
      end
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Checks the UTF-8 class counter against a cycle-free model of its counts.
// Bytes go in on the req channel, one per transfer; each byte with tlast
// closes a string and should produce one rsp transfer with six counts.
module testbench;

   import utf8cc_pkg::*;

   typedef logic [RSP_DATA_W-1:0] tally_word;

   // one queued string byte, end-of-string flag on top
   typedef struct packed {
      logic     last;
      byte_type data;
   } text_item;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // [7:0] text_byte
   logic                   req_tlast;   // end_of_string
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // total, letter, digit, blank, symbol, emoji

   utf8_char_class_counter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // ------------------------------------------------------------------
   // Code point ranges: slots 0-6 count as letters, 7-11 as emoji.
   // Shared by the count model and the stimulus, which aims at the edges.
   // ------------------------------------------------------------------
   point_type class_lo [12] = '{21'h00041, 21'h00400, 21'h00600, 21'h00900, 21'h03040,
                                21'h04E00, 21'h0AC00, 21'h02600, 21'h1F300, 21'h1F600,
                                21'h1F900, 21'h1FA70};
   point_type class_hi [12] = '{21'h0024F, 21'h004FF, 21'h006FF, 21'h0097F, 21'h030FF,
                                21'h09FFF, 21'h0D7AF, 21'h026FF, 21'h1F5FF, 21'h1F64F,
                                21'h1F9FF, 21'h1FAFF};

   string field_name [TALLY_N] = '{"total_points", "letter_count", "digit_count",
                                   "blank_count", "symbol_count", "emoji_count"};

   // ------------------------------------------------------------------
   // Count model state: the open multi-byte sequence and the six tallies
   // ------------------------------------------------------------------
   logic [1:0] open_owed  = '0;   // continuation bytes still to come
   byte_type   open_lead  = '0;
   byte_type   tail_bytes [3];
   logic [1:0] tail_count = '0;
   count_type  tally [TALLY_N] = '{default: '0};

   tally_word  expected_tallies [$];
   text_item   pending_bytes [$];
   byte_type   str_q [$];          // string being assembled by the stimulus

   int         fault_count    = 0;
   int         results_seen   = 0;
   int         bytes_queued   = 0;
   int         strings_queued = 0;
   int         cut_strings    = 0;

   logic       fast_lane = 1'b0;  // no idling on either side while set
   logic       req_fire  = 1'b0;  // req transfer took place at the last rising edge
   int         send_wait = 0;
   int         send_calm = 0;
   int         hold_wait = 0;
   int         hold_calm = 0;
   text_item   cur_item;

   // saturating increment
   function automatic void bump(int slot);
      if (tally[slot] != '1) begin
         tally[slot] = tally[slot] + 1'b1;
      end
   endfunction

   function automatic logic [1:0] follow_count(byte_type b);
      casez (b)
         8'b110?????: return 2'd1;
         8'b1110????: return 2'd2;
         8'b11110???: return 2'd3;
         default:     return 2'd0;
      endcase
   endfunction

   function automatic void tally_ascii(byte_type b);
      bump(TALLY_TOTAL);
      if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
         bump(TALLY_LETTER);
      end else if (b >= "0" && b <= "9") begin
         bump(TALLY_DIGIT);
      end else if (b == 8'h20 || b == 8'h09) begin
         bump(TALLY_BLANK);
      end else if (b inside {"{", "}", "[", "]", "(", ")", ";", "=", "<", ">", "_", "#",
                             "/", "*", "+", "-", "&", "|", "^", "~", 8'h60}) begin
         bump(TALLY_SYMBOL);
      end
   endfunction

   function automatic void tally_point(point_type cp);
      int   r;
      logic is_letter;
      logic is_emoji;
      is_letter = 1'b0;
      is_emoji  = 1'b0;
      for (r = 0; r < 12; r++) begin
         if (cp >= class_lo[r] && cp <= class_hi[r]) begin
            if (r < 7) begin
               is_letter = 1'b1;
            end else begin
               is_emoji = 1'b1;
            end
         end
      end
      bump(TALLY_TOTAL);
      if (is_letter) begin
         bump(TALLY_LETTER);
      end else if (is_emoji) begin
         bump(TALLY_EMOJI);
      end
   endfunction

   // lead payload bits, then six bits from each of k held bytes starting at first
   function automatic point_type assemble(byte_type lead, logic [1:0] k, int first);
      point_type cp;
      int        j;
      case (k)
         2'd1:    cp = point_type'(lead[4:0]);
         2'd2:    cp = point_type'(lead[3:0]);
         default: cp = point_type'(lead[2:0]);
      endcase
      for (j = 0; j < k; j++) begin
         cp = (cp << 6) | point_type'(tail_bytes[first + j][5:0]);
      end
      return cp;
   endfunction

   // Advance the model by one accepted byte; a final byte queues its counts.
   function automatic void absorb_byte(byte_type b, logic last);
      int         i;
      int         s;
      logic [1:0] k;
      tally_word  word;
      if (open_owed == 2'd0) begin
         if (!b[7]) begin
            tally_ascii(b);
         end else begin
            k = follow_count(b);
            // stray byte, or a lead with nothing after it
            if (k == 2'd0 || last) begin
               bump(TALLY_TOTAL);
            end else begin
               open_lead  = b;
               open_owed  = k;
               tail_count = 2'd0;
            end
         end
      end else begin
         tail_bytes[tail_count] = b;
         tail_count = tail_count + 1'b1;
         open_owed  = open_owed - 1'b1;
         if (open_owed == 2'd0) begin
            tally_point(assemble(open_lead, tail_count, 0));
            tail_count = 2'd0;
         end else if (last) begin
            // string cut short: lead counts bare, held bytes are decoded afresh
            bump(TALLY_TOTAL);
            i = 0;
            while (i < tail_count) begin
               k = follow_count(tail_bytes[i]);
               if (!tail_bytes[i][7]) begin
                  tally_ascii(tail_bytes[i]);
                  i++;
               end else if (k != 2'd0 && i + k < tail_count) begin
                  tally_point(assemble(tail_bytes[i], k, i + 1));
                  i += k + 1;
               end else begin
                  bump(TALLY_TOTAL);
                  i++;
               end
            end
            open_owed  = 2'd0;
            tail_count = 2'd0;
         end
      end
      if (last) begin
         for (s = 0; s < TALLY_N; s++) begin
            word[s*COUNT_WIDTH +: COUNT_WIDTH] = tally[s];
            tally[s] = '0;
         end
         expected_tallies.push_back(word);
         open_owed  = 2'd0;
         open_lead  = '0;
         tail_count = 2'd0;
      end
   endfunction

   function automatic void note_fault(string msg);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   // Idle length for either side: mostly none or short, a few long, and now
   // and then a calm stretch with no idling at all.
   function automatic int idle_span(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 6) begin
         calm = $urandom_range(20, 120);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Driver: one queued byte per req transfer, changes on the falling edge.
   // A byte is held until req_fire shows it was taken.
   // ------------------------------------------------------------------
   always @(negedge clock) begin : req_driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (send_wait > 0) begin
            req_tvalid <= 1'b0;
            send_wait  <= send_wait - 1;
         end else if (pending_bytes.size() != 0) begin
            cur_item   = pending_bytes.pop_front();
            req_tdata  <= cur_item.data;
            req_tlast  <= cur_item.last;
            req_tvalid <= 1'b1;
            send_wait  <= fast_lane ? 0 : idle_span(send_calm);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin : rsp_stall
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (fast_lane) begin
         rsp_tready <= 1'b1;
      end else if (hold_wait > 0) begin
         rsp_tready <= 1'b0;
         hold_wait  <= hold_wait - 1;
      end else begin
         rsp_tready <= 1'b1;
         hold_wait  <= idle_span(hold_calm);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge. The result check
   // runs before the byte is absorbed so a same-edge final byte cannot
   // satisfy a stray result.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : watch
      int        s;
      tally_word want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tallies.size() == 0) begin
               note_fault($sformatf("result %0d arrived with nothing expected: %h",
                                    results_seen, rsp_tdata));
            end else begin
               want = expected_tallies.pop_front();
               for (s = 0; s < TALLY_N; s++) begin
                  if (rsp_tdata[s*COUNT_WIDTH +: COUNT_WIDTH] !==
                      want[s*COUNT_WIDTH +: COUNT_WIDTH]) begin
                     note_fault($sformatf("result %0d %s: expected %0d, got %0d",
                                          results_seen, field_name[s],
                                          want[s*COUNT_WIDTH +: COUNT_WIDTH],
                                          rsp_tdata[s*COUNT_WIDTH +: COUNT_WIDTH]));
                  end
               end
            end
            results_seen++;
         end
         if (req_tvalid && req_tready) begin
            absorb_byte(req_tdata, req_tlast);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic flush_string();
      int i;
      for (i = 0; i < str_q.size(); i++) begin
         pending_bytes.push_back(text_item'{last: (i == str_q.size() - 1), data: str_q[i]});
      end
      bytes_queued += str_q.size();
      strings_queued++;
      str_q.delete();
   endtask

   // hold off until every byte is in and every result is back
   task automatic drain_all();
      while (pending_bytes.size() != 0 || req_tvalid || expected_tallies.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // shortest well-formed encoding
   task automatic encode_point(point_type cp);
      if (cp < 21'h80) begin
         str_q.push_back(cp[7:0]);
      end else if (cp < 21'h800) begin
         str_q.push_back({3'b110, cp[10:6]});
         str_q.push_back({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         str_q.push_back({4'b1110, cp[15:12]});
         str_q.push_back({2'b10, cp[11:6]});
         str_q.push_back({2'b10, cp[5:0]});
      end else begin
         str_q.push_back({5'b11110, cp[20:18]});
         str_q.push_back({2'b10, cp[17:12]});
         str_q.push_back({2'b10, cp[11:6]});
         str_q.push_back({2'b10, cp[5:0]});
      end
   endtask

   function automatic byte_type lead_of(int k);
      byte_type r;
      r = byte_type'($urandom_range(0, 255));
      case (k)
         1:       return {3'b110, r[4:0]};
         2:       return {4'b1110, r[3:0]};
         default: return {5'b11110, r[2:0]};
      endcase
   endfunction

   // a point in, or just beside, one of the letter or emoji ranges
   function automatic point_type pick_class_point(logic want_letter);
      int idx;
      idx = want_letter ? $urandom_range(0, 6) : $urandom_range(7, 11);
      case ($urandom_range(0, 5))
         0:       return class_lo[idx];
         1:       return class_hi[idx];
         2:       return class_lo[idx] - 1'b1;
         3:       return class_hi[idx] + 1'b1;
         default: return point_type'($urandom_range(class_lo[idx], class_hi[idx]));
      endcase
   endfunction

   task automatic add_random_point();
      int    k;
      string marks;
      marks = "{}[]();=<>_#/*+-&|^~ \t";
      case ($urandom_range(0, 9))
         0: str_q.push_back(byte_type'($urandom_range(0, 127)));
         1: str_q.push_back(byte_type'(marks[$urandom_range(0, marks.len() - 1)]));
         2: str_q.push_back(byte_type'($urandom_range(8'h30, 8'h7A)));
         3, 4: encode_point(pick_class_point(1'b1));
         5: encode_point(pick_class_point(1'b0));
         6: encode_point(point_type'($urandom_range(0, 21'h1FFFFF)));
         7: begin
            // lead with unchecked tails: overlong and garbage continuations
            k = $urandom_range(1, 3);
            str_q.push_back(lead_of(k));
            repeat (k) str_q.push_back(byte_type'($urandom_range(0, 255)));
         end
         8: begin
            // stray byte: continuation or out-of-range lead
            if ($urandom_range(0, 1) == 0) begin
               str_q.push_back(byte_type'($urandom_range(8'h80, 8'hBF)));
            end else begin
               str_q.push_back(byte_type'($urandom_range(8'hF8, 8'hFF)));
            end
         end
         default: encode_point(point_type'($urandom_range(0, 16'hFFFF)));
      endcase
   endtask

   // mostly well-formed strings, some ending inside a sequence
   task automatic queue_random_string();
      int n;
      int k;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
      repeat (n) add_random_point();
      if ($urandom_range(0, 4) == 0) begin
         k = $urandom_range(1, 3);
         str_q.push_back(lead_of(k));
         repeat ($urandom_range(0, k - 1)) str_q.push_back(byte_type'($urandom_range(0, 255)));
         cut_strings++;
      end
      flush_string();
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin : sequence_ctl
      int rand_start;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ASCII classes and their edges
      str_q = '{8'h00, 8'h41, 8'h7A, 8'h30, 8'h39, 8'h20, 8'h09, 8'h7B, 8'h60, 8'h7F};
      flush_string();
      // stray bytes, an overlong letter, a three-byte and a four-byte emoji
      str_q = '{8'h80, 8'hFF, 8'hC1, 8'h81, 8'hE2, 8'h98, 8'h80, 8'hF0, 8'h9F, 8'h98};
      str_q.push_back(8'h80);
      flush_string();
      // cut short: held tail is a stray
      str_q = '{8'hE4, 8'hB8};
      flush_string();
      // cut short: held bytes form a complete two-byte letter
      str_q = '{8'hF0, 8'hC3, 8'hA9};
      flush_string();
      // lead as the final byte
      str_q = '{8'hF7};
      flush_string();
      // cut short: held lead lacks its tail
      str_q = '{8'hE0, 8'hE0};
      flush_string();
      drain_all();

      // random strings: a full pause after the first part, then a stretch
      // with no idling on either side, then idling again
      rand_start = bytes_queued;
      while (bytes_queued < rand_start + 800) queue_random_string();
      drain_all();
      fast_lane = 1'b1;
      while (bytes_queued < rand_start + 1200) queue_random_string();
      drain_all();
      fast_lane = 1'b0;
      while (bytes_queued < rand_start + 1870) queue_random_string();
      drain_all();

      repeat (10) @(posedge clock);
      $display("Covered %0d strings, %0d bytes, %0d results checked;", strings_queued,
               bytes_queued, results_seen);
      $display("%0d strings ended mid-sequence, one stretch ran with no idling at all.",
               cut_strings);
      if (fault_count == 0 && expected_tallies.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/utf8cc_pkg.sv
rtl/utf8cc_decode.sv
rtl/utf8cc_tally.sv
rtl/utf8_char_class_counter.sv
tb/sv/testbench.sv
